### src/mm_pkg.sv
// Shared types and constants for the matrix multiply block.
`timescale 1ns / 1ps

package mm_pkg;

    localparam int IDX_W   = 3;   // row / column fields
    localparam int DIM_W   = 4;   // size registers
    localparam int VALUE_W = 16;  // Q8.8 input element
    localparam int SUM_W   = 40;  // Q24.16 result element
    localparam int OP_W    = 2;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_A    = 2'd0,
        REG_INNER_LEN = 2'd1,
        REG_COLS_B    = 2'd2,
        REG_UNUSED    = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    // One multiply issued to the MAC pipeline.
    typedef struct packed {
        logic             valid;
        logic             first;      // first product of a dot product
        logic             last_elem;  // final product of a dot product
        logic             last_run;   // belongs to the final element of the run
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } mac_ctl_t;

    // A finished dot product leaving the MAC.
    typedef struct packed {
        logic             valid;
        logic             last_run;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [SUM_W-1:0] sum;
    } mac_res_t;

endpackage

### src/mm_if.sv
// Handshake channels for load/compute items and result elements.
`timescale 1ns / 1ps

interface mm_item_if;
    logic                               valid;
    logic                               ready;
    logic [mm_pkg::OP_W-1:0]            op;
    logic [mm_pkg::IDX_W-1:0]           row;
    logic [mm_pkg::IDX_W-1:0]           col;
    logic signed [mm_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output op, output row, output col, output value,
                    input ready);
    modport sink   (input valid, input op, input row, input col, input value,
                    output ready);
endinterface

interface mm_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [mm_pkg::SUM_W-1:0]    product_sum;
    logic [mm_pkg::IDX_W-1:0]           out_row;
    logic [mm_pkg::IDX_W-1:0]           out_col;
    logic                               last;

    modport source (output valid, output product_sum, output out_row, output out_col,
                    output last, input ready);
    modport sink   (input valid, input product_sum, input out_row, input out_col,
                    input last, output ready);
endinterface

### src/matrix_multiply.sv
// Top level of the matrix multiply block: sequencer, element stores, MAC, result register.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+------------------------------------------
//   item     | in  | valid / ready      | op, row, col, value (Q8.8)
//   result   | out | valid / ready      | product_sum (Q24.16), out_row, out_col, last
//   cfg      | in  | cfg_we, no wait    | cfg_index, cfg_data
//
// After its transfer a compute item holds the input off while the sequencer issues
// rows*cols*inner products, one product per cycle through the single MAC when not frozen;
// the last sum goes from the product register into the result register.
// Reset clears the size registers to 8 and the control state; stores are not cleared.
// A stalled result register freezes the whole read/MAC pipeline.
`timescale 1ns / 1ps

module matrix_multiply #(
    parameter int MAX_DIM    = 8,
    parameter int ELEM_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mm_item_if.sink                         item,
    mm_result_if.source                     result,
    input  logic                            cfg_we,
    input  logic [mm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mm_pkg::DIM_W-1:0]        cfg_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [mm_pkg::DIM_W-1:0] DIM_MAX = mm_pkg::DIM_W'(MAX_DIM);
    localparam logic [mm_pkg::DIM_W-1:0] DIM_ONE = mm_pkg::DIM_W'(1);

    mm_pkg::state_t state_reg, state_next;
    logic [mm_pkg::DIM_W-1:0] rows_a_reg, inner_len_reg, cols_b_reg;
    logic [mm_pkg::DIM_W-1:0] dim_m, dim_k, dim_n;
    logic [mm_pkg::IDX_W-1:0] cnt_i_reg, cnt_j_reg, cnt_l_reg;
    logic [mm_pkg::IDX_W-1:0] cnt_i_next, cnt_j_next, cnt_l_next;

    logic item_xfer, start;
    logic we_a, we_b;
    logic [ELEM_WIDTH-1:0] store_val;
    logic signed [31:0]    value_ext;
    logic [ADDR_W-1:0]     waddr, raddr_a, raddr_b;
    logic [ELEM_WIDTH-1:0] a_data, b_data;

    logic end_l, end_j, end_i;
    logic advance, load_out;
    mm_pkg::mac_ctl_t issue;
    mm_pkg::mac_res_t res;

    logic                            out_valid_reg, out_valid_next;
    logic signed [mm_pkg::SUM_W-1:0] out_sum_reg;
    logic [mm_pkg::IDX_W-1:0]        out_row_reg, out_col_reg;
    logic                            out_last_reg;

    function automatic logic [mm_pkg::DIM_W-1:0] eff_dim(input logic [mm_pkg::DIM_W-1:0] v);
        logic [mm_pkg::DIM_W-1:0] d;
        if (v == '0)
            d = DIM_ONE;
        else if (v > DIM_MAX)
            d = DIM_MAX;
        else
            d = v;
        return d;
    endfunction

    assign dim_m = eff_dim(rows_a_reg);
    assign dim_k = eff_dim(inner_len_reg);
    assign dim_n = eff_dim(cols_b_reg);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= mm_pkg::DIM_W'(8);
            inner_len_reg <= mm_pkg::DIM_W'(8);
            cols_b_reg    <= mm_pkg::DIM_W'(8);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mm_pkg::REG_ROWS_A:    rows_a_reg    <= cfg_data;
                mm_pkg::REG_INNER_LEN: inner_len_reg <= cfg_data;
                mm_pkg::REG_COLS_B:    cols_b_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // loads
    assign item.ready = (state_reg == mm_pkg::ST_IDLE);
    assign item_xfer  = item.valid && item.ready;
    assign start      = item_xfer && (item.op == mm_pkg::OP_COMPUTE);

    assign value_ext = 32'(item.value);
    assign store_val = value_ext[ELEM_WIDTH-1:0];
    assign waddr     = ADDR_W'(int'(item.row) * MAX_DIM + int'(item.col));

    assign we_a = item_xfer && (item.op == mm_pkg::OP_LOAD_A)
                  && ({1'b0, item.row} < dim_m) && ({1'b0, item.col} < dim_k);
    assign we_b = item_xfer && (item.op == mm_pkg::OP_LOAD_B)
                  && ({1'b0, item.row} < dim_k) && ({1'b0, item.col} < dim_n);

    assign raddr_a = ADDR_W'(int'(cnt_i_reg) * MAX_DIM + int'(cnt_l_reg));
    assign raddr_b = ADDR_W'(int'(cnt_l_reg) * MAX_DIM + int'(cnt_j_reg));

    mm_ram #(.DEPTH(DEPTH), .WIDTH(ELEM_WIDTH), .ADDR_W(ADDR_W)) u_store_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (store_val),
        .re    (advance),
        .raddr (raddr_a),
        .rdata (a_data)
    );

    mm_ram #(.DEPTH(DEPTH), .WIDTH(ELEM_WIDTH), .ADDR_W(ADDR_W)) u_store_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (store_val),
        .re    (advance),
        .raddr (raddr_b),
        .rdata (b_data)
    );

    // sequencer: i over rows, j over columns, l over the inner dimension
    assign end_l = ({1'b0, cnt_l_reg} == dim_k - DIM_ONE);
    assign end_j = ({1'b0, cnt_j_reg} == dim_n - DIM_ONE);
    assign end_i = ({1'b0, cnt_i_reg} == dim_m - DIM_ONE);

    always_comb
    begin
        issue.valid     = (state_reg == mm_pkg::ST_RUN);
        issue.first     = (cnt_l_reg == '0);
        issue.last_elem = end_l;
        issue.last_run  = end_i && end_j;
        issue.row       = cnt_i_reg;
        issue.col       = cnt_j_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_i_next = cnt_i_reg;
        cnt_j_next = cnt_j_reg;
        cnt_l_next = cnt_l_reg;
        case (state_reg)
            mm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = mm_pkg::ST_RUN;
                    cnt_i_next = '0;
                    cnt_j_next = '0;
                    cnt_l_next = '0;
                end
            end
            mm_pkg::ST_RUN:
            begin
                if (advance)
                begin
                    if (!end_l)
                    begin
                        cnt_l_next = cnt_l_reg + 1'b1;
                    end
                    else
                    begin
                        cnt_l_next = '0;
                        if (!end_j)
                        begin
                            cnt_j_next = cnt_j_reg + 1'b1;
                        end
                        else
                        begin
                            cnt_j_next = '0;
                            if (end_i)
                                state_next = mm_pkg::ST_IDLE;
                            else
                                cnt_i_next = cnt_i_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = mm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mm_pkg::ST_IDLE;
            cnt_i_reg <= '0;
            cnt_j_reg <= '0;
            cnt_l_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_i_reg <= cnt_i_next;
            cnt_j_reg <= cnt_j_next;
            cnt_l_reg <= cnt_l_next;
        end
    end

    mm_mac #(.ELEM_WIDTH(ELEM_WIDTH)) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .issue   (issue),
        .a_data  (a_data),
        .b_data  (b_data),
        .res     (res)
    );

    // freeze only when a finished sum has nowhere to go
    assign advance  = !(res.valid && out_valid_reg && !result.ready);
    assign load_out = advance && res.valid;

    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_sum_reg  <= res.sum;
            out_row_reg  <= res.row;
            out_col_reg  <= res.col;
            out_last_reg <= res.last_run;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.product_sum = out_sum_reg;
    assign result.out_row     = out_row_reg;
    assign result.out_col     = out_col_reg;
    assign result.last        = out_last_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || result.ready))
        else $error("result register overwritten while holding an untaken element");

    a_stall_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && result.valid && !result.ready) |-> !advance)
        else $error("pipeline advanced with a finished sum and a full result register");

    a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (state_reg == mm_pkg::ST_RUN && cnt_i_reg == '0
                   && cnt_j_reg == '0 && cnt_l_reg == '0))
        else $error("compute run did not start at element zero");

endmodule

### src/mm_ram.sv
// Element store: one write port, one registered read port.
`timescale 1ns / 1ps

module mm_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while the pipeline is stalled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/mm_mac.sv
// Multiply-accumulate pipeline: control follows the RAM read, product, running sum.
`timescale 1ns / 1ps

module mm_mac #(
    parameter int ELEM_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  mm_pkg::mac_ctl_t       issue,
    input  logic [ELEM_WIDTH-1:0]  a_data,
    input  logic [ELEM_WIDTH-1:0]  b_data,
    output mm_pkg::mac_res_t       res
);

    localparam int PROD_W = 2 * ELEM_WIDTH;

    mm_pkg::mac_ctl_t s1_ctl_reg;
    mm_pkg::mac_ctl_t s2_ctl_reg;
    logic signed [mm_pkg::SUM_W-1:0] prod_reg;
    logic signed [mm_pkg::SUM_W-1:0] acc_reg;
    logic signed [mm_pkg::SUM_W-1:0] acc_next;
    logic signed [PROD_W-1:0]        prod;

    assign prod = $signed(a_data) * $signed(b_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
        end
        else if (advance)
        begin
            s1_ctl_reg <= issue;
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    // wraps modulo 2^SUM_W, same as the low bits of a wider sum
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg <= mm_pkg::SUM_W'(prod);
            if (s2_ctl_reg.valid)
            begin
                acc_reg <= acc_next;
            end
        end
    end

    assign acc_next = s2_ctl_reg.first ? prod_reg : acc_reg + prod_reg;

    always_comb
    begin
        res.valid    = s2_ctl_reg.valid && s2_ctl_reg.last_elem;
        res.last_run = s2_ctl_reg.last_run;
        res.row      = s2_ctl_reg.row;
        res.col      = s2_ctl_reg.col;
        res.sum      = acc_next;
    end

endmodule
